// ----- rtl/stl_pkg.sv -----
`default_nettype none

package stl_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_source;
  } item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic        last_token;
  } token_t;

  // up to three tokens caused by one input item, slot 0 goes out first
  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     toks;
  } bundle_t;

  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_FN     = 5'd2;
  localparam logic [4:0] KIND_LET    = 5'd3;
  localparam logic [4:0] KIND_RET    = 5'd4;
  localparam logic [4:0] KIND_INT    = 5'd5;
  localparam logic [4:0] KIND_LPAREN = 5'd6;
  localparam logic [4:0] KIND_RPAREN = 5'd7;
  localparam logic [4:0] KIND_LBRACE = 5'd8;
  localparam logic [4:0] KIND_RBRACE = 5'd9;
  localparam logic [4:0] KIND_SEMI   = 5'd10;
  localparam logic [4:0] KIND_COMMA  = 5'd11;
  localparam logic [4:0] KIND_ASSIGN = 5'd12;
  localparam logic [4:0] KIND_PLUS   = 5'd13;
  localparam logic [4:0] KIND_MINUS  = 5'd14;
  localparam logic [4:0] KIND_ARROW  = 5'd15;
  localparam logic [4:0] KIND_STAR   = 5'd16;
  localparam logic [4:0] KIND_SLASH  = 5'd17;
  localparam logic [4:0] KIND_COLON  = 5'd18;

  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // first three characters of a word, packed
  localparam logic [23:0] KW_FN  = 24'h00666E;
  localparam logic [23:0] KW_LET = 24'h6C6574;
  localparam logic [23:0] KW_RET = 24'h726574;

endpackage

`default_nettype wire

// ----- rtl/stl_front.sv -----
`default_nettype none

module stl_front #(
  parameter int unsigned PW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stl_pkg::item_t   item_i,
  input  wire logic             accept_i,
  output stl_pkg::bundle_t      bundle_o
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;
  localparam logic [1:0] MODE_MINUS = 2'd3;

  logic [1:0]    mode_q, mode_d;
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] run_q, run_d;
  logic [23:0]   kp_q, kp_d;
  logic [7:0]    c;
  logic          done;
  stl_pkg::bundle_t b;

  function automatic logic [15:0] to16(logic [PW-1:0] v);
    logic [PW+15:0] e;
    e = {16'b0, v};
    return e[15:0];
  endfunction

  function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
    return (v == '1) ? v : v + PW'(1);
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] ch);
    return ch inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [4:0] symbol_kind(logic [7:0] ch);
    case (ch)
      8'h28:   return stl_pkg::KIND_LPAREN;
      8'h29:   return stl_pkg::KIND_RPAREN;
      8'h7B:   return stl_pkg::KIND_LBRACE;
      8'h7D:   return stl_pkg::KIND_RBRACE;
      8'h3B:   return stl_pkg::KIND_SEMI;
      8'h2C:   return stl_pkg::KIND_COMMA;
      8'h3D:   return stl_pkg::KIND_ASSIGN;
      8'h2B:   return stl_pkg::KIND_PLUS;
      8'h2A:   return stl_pkg::KIND_STAR;
      8'h2F:   return stl_pkg::KIND_SLASH;
      8'h3A:   return stl_pkg::KIND_COLON;
      default: return stl_pkg::KIND_EOF;
    endcase
  endfunction

  function automatic stl_pkg::token_t mk(logic [4:0] kind, logic [15:0] s,
                                         logic [15:0] l, logic last);
    stl_pkg::token_t t;
    t.token_kind   = kind;
    t.start_pos    = s;
    t.token_length = l;
    t.last_token   = last;
    return t;
  endfunction

  function automatic stl_pkg::bundle_t push_tok(stl_pkg::bundle_t bi,
                                                stl_pkg::token_t t);
    stl_pkg::bundle_t r;
    r = bi;
    case (bi.cnt)
      2'd0: begin
        r.toks[0] = t;
        r.cnt     = 2'd1;
      end
      2'd1: begin
        r.toks[1] = t;
        r.cnt     = 2'd2;
      end
      2'd2: begin
        r.toks[2] = t;
        r.cnt     = 2'd3;
      end
      default: r = bi;
    endcase
    return r;
  endfunction

  function automatic stl_pkg::bundle_t flush(stl_pkg::bundle_t bi, logic [1:0] m,
                                             logic [PW-1:0] s, logic [PW-1:0] run,
                                             logic [23:0] kp);
    stl_pkg::bundle_t r;
    logic [4:0] k;
    r = bi;
    k = stl_pkg::KIND_IDENT;
    if (run == PW'(2) && kp == stl_pkg::KW_FN) begin
      k = stl_pkg::KIND_FN;
    end else if (run == PW'(3) && kp == stl_pkg::KW_LET) begin
      k = stl_pkg::KIND_LET;
    end else if (run == PW'(3) && kp == stl_pkg::KW_RET) begin
      k = stl_pkg::KIND_RET;
    end
    case (m)
      MODE_IDENT: r = push_tok(bi, mk(k, to16(s), to16(run), 1'b0));
      MODE_INT:   r = push_tok(bi, mk(stl_pkg::KIND_INT, to16(s), to16(run), 1'b0));
      MODE_MINUS: r = push_tok(bi, mk(stl_pkg::KIND_MINUS, to16(s), 16'd1, 1'b0));
      default:    r = bi;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    run_d   = run_q;
    kp_d    = kp_q;
    b       = '0;
    done    = 1'b0;
    c       = item_i.char_byte;
    if (item_i.has_char) begin
      if (mode_q == MODE_MINUS) begin
        if (c == stl_pkg::CH_GT) begin
          b    = push_tok(b, mk(stl_pkg::KIND_ARROW, to16(start_q), 16'd2, 1'b0));
          done = 1'b1;
        end else begin
          b = flush(b, mode_q, start_q, run_q, kp_q);
        end
        mode_d = MODE_IDLE;
      end
      if (!done) begin
        if ((mode_d == MODE_IDENT && (is_alpha(c) || is_digit(c) ||
             c == stl_pkg::CH_UNDERSCORE)) ||
            (mode_d == MODE_INT && is_digit(c))) begin
          if (run_d < PW'(3)) begin
            kp_d = {kp_d[15:0], c};
          end
          run_d = sat_inc(run_d);
        end else begin
          b      = flush(b, mode_d, start_d, run_d, kp_d);
          mode_d = MODE_IDLE;
          if (is_space(c)) begin
            mode_d = MODE_IDLE;
          end else if (is_alpha(c) || c == stl_pkg::CH_UNDERSCORE || is_digit(c)) begin
            mode_d  = is_digit(c) ? MODE_INT : MODE_IDENT;
            start_d = pos_q;
            run_d   = PW'(1);
            kp_d    = {16'b0, c};
          end else if (c == stl_pkg::CH_MINUS) begin
            mode_d  = MODE_MINUS;
            start_d = pos_q;
          end else if (symbol_kind(c) != stl_pkg::KIND_EOF) begin
            b = push_tok(b, mk(symbol_kind(c), to16(pos_q), 16'd1, 1'b0));
          end
        end
      end
      pos_d = sat_inc(pos_q);
    end
    if (item_i.end_of_source) begin
      b       = flush(b, mode_d, start_d, run_d, kp_d);
      b       = push_tok(b, mk(stl_pkg::KIND_EOF, to16(pos_d), 16'd0, 1'b1));
      mode_d  = MODE_IDLE;
      start_d = '0;
      pos_d   = '0;
      run_d   = '0;
      kp_d    = '0;
    end
  end

  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      run_q   <= '0;
      kp_q    <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      kp_q    <= kp_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.end_of_source |=> mode_q == MODE_IDLE && pos_q == '0)
    else $error("scan state not cleared after end of source");

  a_end_has_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.end_of_source |-> bundle_o.cnt != 2'd0)
    else $error("end of source without eof token");

endmodule

`default_nettype wire

// ----- rtl/stl_queue.sv -----
`default_nettype none

module stl_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire stl_pkg::bundle_t data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output stl_pkg::bundle_t      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  stl_pkg::bundle_t mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_i && !full_o;
  assign rd      = rd_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({wr, rd})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill count out of range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("write into full queue");

endmodule

`default_nettype wire

// ----- rtl/stl_back.sv -----
`default_nettype none

module stl_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire stl_pkg::bundle_t head_i,
  input  wire logic             head_valid_i,
  output logic                  head_pop_o,
  output stl_pkg::token_t       token_o,
  output logic                  empty_o,
  input  wire logic             pop_i
);

  logic [1:0] idx_q, idx_d;
  logic       xfer, last;

  assign empty_o    = !head_valid_i;
  assign xfer       = pop_i && head_valid_i;
  assign last       = (idx_q == head_i.cnt - 2'd1);
  assign head_pop_o = xfer && last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    token_o = head_i.toks[0];
      2'd1:    token_o = head_i.toks[1];
      2'd2:    token_o = head_i.toks[2];
      default: token_o = head_i.toks[0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_i.cnt)
    else $error("token index past end of bundle");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 2'd0)
    else $error("token index not rewound with queue empty");

endmodule

`default_nettype wire

// ----- rtl/source_token_lexer.sv -----
`default_nettype none

// channel   direction  handshake          payload
// source    in         push / full        item_i  (char_byte, has_char, end_of_source)
// tokens    out        pop / empty        token_o (token_kind, start_pos, token_length,
//                                                  last_token)
//
// one source byte per cycle enters the scanner while full is low; its tokens
// (up to three) are queued as one group and leave one token per cycle on pop
// a token shows on token_o at the earliest in the cycle after the transfer completing it
// full rises when the group queue holds QUEUE_DEPTH groups
// reset clears scanner state and the queue at once, no clearing pass

module source_token_lexer #(
  parameter int unsigned POS_WIDTH   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  input  wire stl_pkg::item_t  item_i,
  output logic                 full,
  output stl_pkg::token_t      token_o,
  output logic                 empty,
  input  wire logic            pop
);

  stl_pkg::bundle_t front_bundle;
  stl_pkg::bundle_t head_bundle;
  logic             accept;
  logic             q_full, q_empty, head_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  stl_front #(
    .PW(POS_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .accept_i (accept),
    .bundle_o (front_bundle)
  );

  stl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept && front_bundle.cnt != 2'd0),
    .data_i  (front_bundle),
    .full_o  (q_full),
    .rd_i    (head_pop),
    .data_o  (head_bundle),
    .empty_o (q_empty)
  );

  stl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_bundle),
    .head_valid_i (!q_empty),
    .head_pop_o   (head_pop),
    .token_o      (token_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

`default_nettype wire
